@@ design/mlc_pkg.sv @@
// ----------------------------------------------------------------------------
// mlc_pkg
// Shared types and constants for the min line container (lower-envelope
// line store).
// ----------------------------------------------------------------------------
package mlc_pkg;

    localparam int X_SPAN_DEF = 1024;

    localparam int SLOPE_W = 32;
    localparam int ICPT_W  = 48;
    localparam int QP_W    = 10;
    localparam int MIN_W   = 61;

    localparam int S_SLOPE_LSB = 0;
    localparam int S_ICPT_LSB  = S_SLOPE_LSB + SLOPE_W;
    localparam int S_QP_LSB    = S_ICPT_LSB + ICPT_W;
    localparam int S_TDATA_W   = 96;
    localparam int M_TDATA_W   = 64;

    localparam logic [MIN_W-1:0] EMPTY_VALUE = 61'd1000000000000000000;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    // evaluation slots, issued in this order
    localparam logic [2:0] EV_TL      = 3'd0;
    localparam logic [2:0] EV_TR      = 3'd1;
    localparam logic [2:0] EV_NL      = 3'd2;
    localparam logic [2:0] EV_NR      = 3'd3;
    localparam logic [2:0] EV_TM      = 3'd4;
    localparam logic [2:0] EV_NM      = 3'd5;
    localparam logic [2:0] EV_INS_END = 3'd6;
    localparam logic [2:0] EV_QRY_END = 3'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WAIT,
        ST_EVAL,
        ST_DECIDE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic                      valid;
        logic signed [SLOPE_W-1:0] slope;
        logic signed [ICPT_W-1:0]  icpt;
    } node_t;

endpackage

@@ design/mlc_ram.sv @@
// ----------------------------------------------------------------------------
// mlc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module mlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/mlc_line_eval.sv @@
// ----------------------------------------------------------------------------
// mlc_line_eval
// Shared line evaluator: y = a*x + b, one registered result per cycle.
// ----------------------------------------------------------------------------
module mlc_line_eval #(
    parameter int XW = 10,
    parameter int VW = (((33 + XW) > 48) ? (33 + XW) : 48) + 1
) (
    input  logic                              aclk,
    input  logic signed [mlc_pkg::SLOPE_W-1:0] a,
    input  logic signed [mlc_pkg::ICPT_W-1:0]  b,
    input  logic        [XW-1:0]              x,
    output logic signed [VW-1:0]              y
);
    import mlc_pkg::*;

    localparam int PW = SLOPE_W + XW + 1;

    logic signed [PW-1:0] a_ext;
    logic signed [PW-1:0] x_ext;
    logic signed [PW-1:0] prod;
    logic signed [VW-1:0] y_next;

    assign a_ext  = PW'(a);
    assign x_ext  = $signed(PW'({1'b0, x}));
    assign prod   = a_ext * x_ext;
    assign y_next = VW'(prod) + VW'(b);

    always_ff @(posedge aclk) begin
        y <= y_next;
    end

endmodule

@@ design/min_line_container_unit.sv @@
// ----------------------------------------------------------------------------
// min_line_container_unit
// Lower-envelope store of integer lines over 0..X_SPAN-1 (min line tree):
// insert a line, or query the minimum over stored lines at a point.
//
//   channel | dir | tdata                                  | tuser
//   --------+-----+----------------------------------------+-----------------
//   s_      | in  | slope[31:0] intercept[79:32] qp[89:80] | func (1=query)
//   m_      | out | min_value[60:0]                        | is_empty
//
// After reset a clearing pass wipes every entry of the node store; the
// input is not ready until it ends.
// One transaction at a time. Per tree level: node read, then the shared
// multiply-add unit (stored and new line at lo, hi, mid on insert; stored
// line at query point on query), then decide. Up to log2(X_SPAN)+1 levels.
// Results sit in an output register; a query waits only if it is still full.
// ----------------------------------------------------------------------------
module min_line_container_unit #(
    parameter int X_SPAN = mlc_pkg::X_SPAN_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mlc_pkg::S_TDATA_W-1:0]  s_tdata,   // slope, intercept, query_point
    input  logic                           s_tuser,   // func
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mlc_pkg::M_TDATA_W-1:0]  m_tdata,   // min_value
    output logic                           m_tuser    // is_empty
);
    import mlc_pkg::*;

    localparam int XW         = $clog2(X_SPAN);
    localparam int VW         = (((33 + XW) > 48) ? (33 + XW) : 48) + 1;
    localparam int NODE_COUNT = 4 * X_SPAN;
    localparam int AW         = $clog2(NODE_COUNT);

    state_t state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic func_reg, func_next;
    logic signed [SLOPE_W-1:0] cur_slope_reg, cur_slope_next;
    logic signed [ICPT_W-1:0]  cur_icpt_reg, cur_icpt_next;
    logic signed [SLOPE_W-1:0] node_slope_reg, node_slope_next;
    logic signed [ICPT_W-1:0]  node_icpt_reg, node_icpt_next;
    logic [XW-1:0] qx_reg, qx_next;
    logic [XW-1:0] lo_reg, lo_next;
    logic [XW-1:0] hi_reg, hi_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic signed [VW-1:0] best_reg, best_next;
    logic none_reg, none_next;
    logic m_valid_reg, m_valid_next;
    logic [MIN_W-1:0] m_data_reg, m_data_next;
    logic m_empty_reg, m_empty_next;
    logic signed [VW-1:0] ev_reg [6];

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    node_t         ram_wdata;
    node_t         ram_rdata;

    logic signed [SLOPE_W-1:0] ev_a;
    logic signed [ICPT_W-1:0]  ev_b;
    logic [XW-1:0]             ev_x;
    logic signed [VW-1:0]      ev_y;

    logic [XW-1:0] mid;
    logic [31:0]   qp_ext;
    logic          swap;
    logic          go_right;
    logic [AW:0]   child_idx;
    logic          out_free;

    mlc_ram #(
        .WIDTH ($bits(node_t)),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    mlc_line_eval #(
        .XW (XW),
        .VW (VW)
    ) u_eval (
        .aclk (aclk),
        .a    (ev_a),
        .b    (ev_b),
        .x    (ev_x),
        .y    (ev_y)
    );

    assign mid      = XW'(((XW+1)'(lo_reg) + (XW+1)'(hi_reg)) >> 1);
    assign qp_ext   = 32'(s_tdata[S_QP_LSB +: QP_W]);
    assign swap     = ev_reg[EV_TM] > ev_reg[EV_NM];
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        logic signed [VW-1:0] wl;
        logic signed [VW-1:0] ll;
        wl = swap ? ev_reg[EV_NL] : ev_reg[EV_TL];
        ll = swap ? ev_reg[EV_TL] : ev_reg[EV_NL];
        if (func_reg == FUNC_QUERY) begin
            go_right = qx_reg > mid;
        end else begin
            go_right = !(wl >= ll);
        end
        child_idx = {idx_reg, go_right};
    end

    always_comb begin
        ev_a = node_slope_reg;
        ev_b = node_icpt_reg;
        ev_x = lo_reg;
        if (func_reg == FUNC_QUERY) begin
            ev_x = qx_reg;
        end else begin
            unique case (step_reg)
                EV_TL: begin
                    ev_x = lo_reg;
                end
                EV_TR: begin
                    ev_x = hi_reg;
                end
                EV_NL: begin
                    ev_a = cur_slope_reg;
                    ev_b = cur_icpt_reg;
                    ev_x = lo_reg;
                end
                EV_NR: begin
                    ev_a = cur_slope_reg;
                    ev_b = cur_icpt_reg;
                    ev_x = hi_reg;
                end
                EV_TM: begin
                    ev_x = mid;
                end
                EV_NM: begin
                    ev_a = cur_slope_reg;
                    ev_b = cur_icpt_reg;
                    ev_x = mid;
                end
                default: begin
                    ev_x = lo_reg;
                end
            endcase
        end
    end

    always_comb begin
        state_next      = state_reg;
        step_next       = step_reg;
        func_next       = func_reg;
        cur_slope_next  = cur_slope_reg;
        cur_icpt_next   = cur_icpt_reg;
        node_slope_next = node_slope_reg;
        node_icpt_next  = node_icpt_reg;
        qx_next         = qx_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        idx_next        = idx_reg;
        clr_next        = clr_reg;
        best_next       = best_reg;
        none_next       = none_reg;
        m_data_next     = m_data_reg;
        m_empty_next    = m_empty_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        s_tready        = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = '{valid: 1'b1, slope: cur_slope_reg, icpt: cur_icpt_reg};

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(NODE_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    func_next      = s_tuser;
                    cur_slope_next = s_tdata[S_SLOPE_LSB +: SLOPE_W];
                    cur_icpt_next  = s_tdata[S_ICPT_LSB +: ICPT_W];
                    if (qp_ext > 32'(X_SPAN - 1)) begin
                        qx_next = XW'(X_SPAN - 1);
                    end else begin
                        qx_next = XW'(qp_ext);
                    end
                    idx_next   = AW'(1);
                    lo_next    = '0;
                    hi_next    = XW'(X_SPAN - 1);
                    best_next  = '0;
                    none_next  = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                node_slope_next = ram_rdata.slope;
                node_icpt_next  = ram_rdata.icpt;
                step_next       = EV_TL;
                if (ram_rdata.valid) begin
                    state_next = ST_EVAL;
                end else if (func_reg == FUNC_QUERY) begin
                    state_next = ST_RESULT;
                end else begin
                    ram_we     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EVAL: begin
                step_next = step_reg + 3'd1;
                if ((func_reg == FUNC_QUERY && step_reg == EV_QRY_END) ||
                    (func_reg == FUNC_INSERT && step_reg == EV_INS_END)) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (func_reg == FUNC_QUERY) begin
                    if (none_reg || ev_reg[EV_TL] < best_reg) begin
                        best_next = ev_reg[EV_TL];
                    end
                    none_next = 1'b0;
                    if (lo_reg == hi_reg) begin
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_READ;
                    end
                end else if (ev_reg[EV_TL] <= ev_reg[EV_NL] &&
                             ev_reg[EV_TR] <= ev_reg[EV_NR]) begin
                    state_next = ST_IDLE;
                end else if (ev_reg[EV_TL] >= ev_reg[EV_NL] &&
                             ev_reg[EV_TR] >= ev_reg[EV_NR]) begin
                    ram_we     = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    if (swap) begin
                        ram_we         = 1'b1;
                        cur_slope_next = node_slope_reg;
                        cur_icpt_next  = node_icpt_reg;
                    end
                    state_next = ST_READ;
                end
                if (state_next == ST_READ) begin
                    if (go_right) begin
                        lo_next = mid + XW'(1);
                    end else begin
                        hi_next = mid;
                    end
                    idx_next = child_idx[AW-1:0];
                    if (child_idx >= (AW+1)'(NODE_COUNT)) begin
                        state_next = (func_reg == FUNC_QUERY) ? ST_RESULT : ST_IDLE;
                    end
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_empty_next = none_reg;
                    m_data_next  = none_reg ? EMPTY_VALUE : MIN_W'(best_reg);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            step_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            step_reg    <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        cur_slope_reg  <= cur_slope_next;
        cur_icpt_reg   <= cur_icpt_next;
        node_slope_reg <= node_slope_next;
        node_icpt_reg  <= node_icpt_next;
        qx_reg         <= qx_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        idx_reg        <= idx_next;
        best_reg       <= best_next;
        none_reg       <= none_next;
        m_data_reg     <= m_data_next;
        m_empty_reg    <= m_empty_next;
        if (state_reg == ST_EVAL && step_reg != EV_TL) begin
            ev_reg[step_reg - 3'd1] <= ev_y;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_data_reg);
    assign m_tuser  = m_empty_reg;

`ifndef SYNTH
    a_no_write_on_query: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg != ST_CLEAR) |-> (func_reg == FUNC_INSERT))
        else $error("node store written during a query");

    a_empty_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[MIN_W-1:0] == EMPTY_VALUE))
        else $error("empty result without sentinel value");

    a_span_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (lo_reg <= hi_reg && idx_reg != '0))
        else $error("tree walk lost its range");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_RESULT))
        else $error("result raised outside result state");
`endif

endmodule

@@ sim/mlc_checker.sv @@
// ----------------------------------------------------------------------------
// mlc_checker
// Watches both stream channels of the min line container. Keeps its own
// line tree, updated on every accepted insert, works out the minimum for
// every accepted query and compares each returned result with the oldest
// outstanding one.
// ----------------------------------------------------------------------------
module mlc_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [mlc_pkg::S_TDATA_W-1:0]  s_tdata,    // slope, intercept, query_point
    input  logic                           s_tuser,    // func
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [mlc_pkg::M_TDATA_W-1:0]  m_tdata,    // min_value
    input  logic                           m_tuser,    // is_empty
    output int                             err_count,
    output int                             pending,
    output int                             results_seen,
    output int                             empty_hits
);
    timeunit 1ns;
    timeprecision 1ps;
    import mlc_pkg::*;

    localparam int     TREE_NODES = 4 * X_SPAN_DEF;
    localparam longint X_LAST     = X_SPAN_DEF - 1;
    localparam longint EMPTY_MIN  = longint'(EMPTY_VALUE);

    typedef struct packed {
        logic [MIN_W-1:0] min_value;
        logic             is_empty;
    } min_result_t;

    longint      line_slope [TREE_NODES];
    longint      line_icpt  [TREE_NODES];
    bit          line_valid [TREE_NODES];
    min_result_t min_results_q [$];

    function automatic longint line_at(input longint a, input longint b, input longint x);
        return a * x + b;
    endfunction

    function automatic void envelope_insert(input longint a_in, input longint b_in);
        longint a, b, ta, tb, lo, hi, mid;
        longint tl, tr, nl, nr, tm, nm, wl, ll;
        int     idx;
        a   = a_in;
        b   = b_in;
        idx = 1;
        lo  = 0;
        hi  = X_LAST;
        while (idx < TREE_NODES) begin
            if (!line_valid[idx]) begin
                line_slope[idx] = a;
                line_icpt[idx]  = b;
                line_valid[idx] = 1'b1;
                return;
            end
            ta = line_slope[idx];
            tb = line_icpt[idx];
            tl = line_at(ta, tb, lo);
            tr = line_at(ta, tb, hi);
            nl = line_at(a, b, lo);
            nr = line_at(a, b, hi);
            if (tl <= nl && tr <= nr)
                return;
            if (tl >= nl && tr >= nr) begin
                line_slope[idx] = a;
                line_icpt[idx]  = b;
                return;
            end
            mid = (lo + hi) / 2;
            tm  = line_at(ta, tb, mid);
            nm  = line_at(a, b, mid);
            if (tm > nm) begin
                // new line takes the node, stored line moves down
                line_slope[idx] = a;
                line_icpt[idx]  = b;
                wl = nl;
                ll = tl;
                a  = ta;
                b  = tb;
            end else begin
                wl = tl;
                ll = nl;
            end
            if (wl >= ll) begin
                idx = idx * 2;
                hi  = mid;
            end else begin
                idx = idx * 2 + 1;
                lo  = mid + 1;
            end
        end
    endfunction

    function automatic min_result_t envelope_min_at(input longint x);
        min_result_t r;
        longint      best, v, lo, hi, mid;
        bit          none;
        int          idx;
        idx  = 1;
        lo   = 0;
        hi   = X_LAST;
        best = EMPTY_MIN;
        none = 1'b1;
        while (idx < TREE_NODES && line_valid[idx]) begin
            v = line_at(line_slope[idx], line_icpt[idx], x);
            if (none || v < best)
                best = v;
            none = 1'b0;
            if (lo == hi)
                break;
            mid = (lo + hi) / 2;
            if (x <= mid) begin
                idx = idx * 2;
                hi  = mid;
            end else begin
                idx = idx * 2 + 1;
                lo  = mid + 1;
            end
        end
        if (none || best > EMPTY_MIN)
            best = EMPTY_MIN;
        r.min_value = best[MIN_W-1:0];
        r.is_empty  = none;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (err_count < 40)
            $display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, what);
        err_count++;
    endtask

    always @(posedge aclk) begin
        min_result_t want;
        longint      qx;
        if (!aresetn) begin
            foreach (line_valid[i])
                line_valid[i] = 1'b0;
            min_results_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                if (s_tuser == FUNC_QUERY) begin
                    qx = longint'(s_tdata[S_QP_LSB +: QP_W]);
                    if (qx > X_LAST)
                        qx = X_LAST;
                    min_results_q.push_back(envelope_min_at(qx));
                end else begin
                    envelope_insert(longint'($signed(s_tdata[S_SLOPE_LSB +: SLOPE_W])),
                                    longint'($signed(s_tdata[S_ICPT_LSB +: ICPT_W])));
                end
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (m_tuser)
                    empty_hits++;
                if (min_results_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction min_value=%0d is_empty=%0b",
                                              $signed(m_tdata[MIN_W-1:0]), m_tuser));
                end else begin
                    want = min_results_q.pop_front();
                    if (m_tdata[MIN_W-1:0] !== want.min_value)
                        report_mismatch($sformatf("min_value got %0d want %0d",
                                                  $signed(m_tdata[MIN_W-1:0]),
                                                  $signed(want.min_value)));
                    if (m_tuser !== want.is_empty)
                        report_mismatch($sformatf("is_empty got %0b want %0b",
                                                  m_tuser, want.is_empty));
                end
            end
        end
        pending = min_results_q.size();
    end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the min line container. A short directed opening
// hits the empty store, drops, replacements, crossings and slope extremes;
// then epochs of random lines, each epoch lower than the last, so the tree
// is rebuilt and pushed deep again and again, mixed with queries. A closing
// block inserts the most negative intercepts, then a most positive one, with queries. Checking is in mlc_checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mlc_pkg::*;

    localparam int     ITEMS_RANDOM = 1950;
    localparam int     IDLE_STOP    = ITEMS_RANDOM * 85 / 100;
    localparam int     CYCLE_LIMIT  = 1_000_000;
    localparam int     DRAIN_CYCLES = 200;
    localparam longint SLOPE_MAX    = (longint'(1) << 31) - 1;
    localparam longint SLOPE_MIN    = -(longint'(1) << 31);
    localparam longint ICPT_MAX     = (longint'(1) << 47) - 1;
    localparam longint ICPT_MIN     = -(longint'(1) << 47);
    localparam longint BASE_START   = -(longint'(1) << 40);
    localparam longint BASE_STEP    = longint'(1) << 41;
    localparam longint BASE_FLOOR   = -(longint'(60) << 41);

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;    // slope, intercept, query_point
    logic                  s_tuser;    // func
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;    // min_value
    logic                  m_tuser;    // is_empty

    int     err_count;
    int     pending;
    int     results_seen;
    int     empty_hits;
    bit     idle_on;
    int     n_insert;
    int     n_query;
    int     n_epoch;
    int     cycles;
    longint ring_a [16];
    longint ring_b [16];
    int     ring_pos;

    always #6 aclk = ~aclk;

    min_line_container_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    mlc_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .err_count    (err_count),
        .pending      (pending),
        .results_seen (results_seen),
        .empty_hits   (empty_hits)
    );

    function automatic longint rand_span(input longint mag);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return longint'(r >> 1) % (2 * mag + 1) - mag;
    endfunction

    // node boundary or midpoint at a random tree depth
    function automatic int tree_point(input bit mid_only);
        int depth, span, lo;
        depth = $urandom_range(0, 9);
        span  = X_SPAN_DEF >> depth;
        lo    = span * $urandom_range(0, (1 << depth) - 1);
        if (mid_only)
            return lo + span / 2 - 1;
        case ($urandom_range(0, 3))
            0: return lo;
            1: return lo + span - 1;
            2: return lo + span / 2 - 1;
            default: return lo + span / 2;
        endcase
    endfunction

    task automatic send_item(input logic func, input logic [S_TDATA_W-1:0] payload);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= payload;
        s_tuser  <= func;
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    task automatic send_insert(input longint a, input longint b);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[S_SLOPE_LSB +: SLOPE_W] = a[SLOPE_W-1:0];
        d[S_ICPT_LSB +: ICPT_W]   = b[ICPT_W-1:0];
        d[S_QP_LSB +: QP_W]       = QP_W'($urandom_range(0, 1023));
        ring_a[ring_pos] = a;
        ring_b[ring_pos] = b;
        ring_pos = (ring_pos + 1) % 16;
        n_insert++;
        send_item(FUNC_INSERT, d);
    endtask

    task automatic send_query(input int x);
        logic [S_TDATA_W-1:0] d;
        logic [63:0]          junk;
        junk = {$urandom, $urandom};
        d = '0;
        d[S_SLOPE_LSB +: SLOPE_W] = $urandom;
        d[S_ICPT_LSB +: ICPT_W]   = junk[ICPT_W-1:0];
        d[S_QP_LSB +: QP_W]       = QP_W'(x);
        n_query++;
        send_item(FUNC_QUERY, d);
    endtask

    // result side back-pressure
    initial begin
        int hold;
        hold = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                hold = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        longint base, scale, pivot_off, a, b;
        int     sent, ep_len, j, pick, k, m, slot, x;
        idle_on  = 1'b0;
        ring_pos = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= FUNC_INSERT;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        idle_on = 1'b1;

        // empty store, drop, replace, crossings, slope extremes
        send_query(0);
        send_query(1023);
        send_query(512);
        send_insert(0, 0);
        send_query(0);
        send_insert(0, 5);
        send_insert(0, -5);
        send_insert(1, -600);
        send_insert(-1, 400);
        send_insert(0, -5);
        send_insert(3, -1533);
        send_insert(SLOPE_MAX, 0);
        send_insert(SLOPE_MIN, ICPT_MAX);
        send_insert(SLOPE_MIN, -SLOPE_MIN * 1023 - 10000);
        send_query(0);
        send_query(511);
        send_query(512);
        send_query(595);
        send_query(1023);
        send_query(300);

        sent    = 0;
        n_epoch = 0;
        while (sent < ITEMS_RANDOM) begin
            ep_len = $urandom_range(40, 100);
            base   = BASE_START - n_epoch * BASE_STEP;
            if (base < BASE_FLOOR)
                base = BASE_FLOOR;
            scale     = longint'(1) << $urandom_range(0, 12);
            pivot_off = rand_span(1 << 20);
            idle_on   = (sent < IDLE_STOP) && ($urandom_range(0, 9) < 7);
            for (j = 0; j < ep_len && sent < ITEMS_RANDOM; j++) begin
                if (sent >= IDLE_STOP)
                    idle_on = 1'b0;
                if ($urandom_range(0, 99) < 45) begin
                    x = ($urandom_range(0, 4) == 0) ? tree_point(1'b0) : $urandom_range(0, 1023);
                    send_query(x);
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 40) begin
                        // tangents of a concave curve: all of them shape the envelope
                        k = $urandom_range(0, 1023);
                        a = -2 * scale * k;
                        b = base + scale * k * k + longint'($urandom_range(0, 3));
                    end else if (pick < 65) begin
                        a = rand_span(1 << 20);
                        b = base + rand_span(longint'(1) << 30);
                    end else if (pick < 75) begin
                        a = longint'($signed($urandom));
                        b = base + rand_span(longint'(1) << 38);
                    end else if (pick < 87) begin
                        // lines through one point at a node midpoint: ties there
                        m = tree_point(1'b1);
                        a = rand_span(1 << 16);
                        b = base + pivot_off - a * m;
                    end else begin
                        slot = $urandom_range(0, 15);
                        a = ring_a[slot];
                        b = ring_b[slot] + longint'($urandom_range(0, 2)) - 1;
                    end
                    send_insert(a, b);
                end
                sent++;
            end
            n_epoch++;
        end

        idle_on = 1'b0;
        send_insert(SLOPE_MAX, ICPT_MIN);
        send_query(0);
        send_query(1023);
        send_insert(SLOPE_MIN, ICPT_MIN);
        send_query(0);
        send_query(511);
        send_query(512);
        send_query(1023);
        send_insert(SLOPE_MIN, ICPT_MAX);
        send_query($urandom_range(0, 1023));
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d line inserts and %0d minimum queries over %0d envelope epochs",
                 n_insert, n_query, n_epoch);
        $display("%0d results checked, %0d on an empty path, %0d mismatches",
                 results_seen, empty_hits, err_count);
        if (err_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
